// ===== sv/pfa_pkg.sv =====
// Shared types and constants of the page-frame allocator.
`default_nettype none

package pfa_pkg;

    localparam int NUM_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int REG_W      = 11;
    localparam int CNT_W      = 8;
    localparam int ADDR_W     = 22;
    localparam int IN_ADDR_W  = 32;
    localparam int IDX_W      = 3;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    typedef enum logic [1:0] {
        STS_ALLOC   = 2'd0,
        STS_OOM     = 2'd1,
        STS_FREED   = 2'd2,
        STS_IGNORED = 2'd3
    } t_pfa_status;

    typedef enum logic [IDX_W-1:0] {
        REG_MEM_PAGES   = 3'd0,
        REG_MMIO_FIRST  = 3'd1,
        REG_MMIO_LIMIT  = 3'd2,
        REG_KERN_FIRST  = 3'd3,
        REG_KERN_END    = 3'd4,
        REG_STACK_PAGE  = 3'd5
    } t_pfa_reg;

    localparam logic OP_ALLOC = 1'b0;

    typedef struct packed {
        logic [REG_W-1:0] mem_pages;
        logic [REG_W-1:0] mmio_first;
        logic [REG_W-1:0] mmio_limit;
        logic [REG_W-1:0] kern_first;
        logic [REG_W-1:0] kern_end;
        logic [REG_W-1:0] stack_page;
    } t_pfa_cfg;

endpackage

`default_nettype wire

// ===== sv/page_frame_allocator.sv =====
// Top level of the first-fit physical page-frame allocator.
`default_nettype none

// The allocator keeps an 8-bit reference count per page frame in one
// synchronous RAM. After reset it first runs a clearing pass that zeroes the
// RAM one entry a cycle; no request beat is taken during that pass, but
// configuration writes are. One request is worked on at a time. An allocate
// beat reads the count RAM one page per cycle upward from page 0 and stops at
// the first allocatable page with a zero count, or after the last page when
// memory is exhausted; the single read port of the count RAM sets that rate.
// A free beat reads the count, decides, and writes the count back together
// with the result. The result sits in an output register, so a new request
// beat is accepted while an earlier result still waits to be taken.
// Configuration is written through a plain write port and must only change
// while no request is in flight.
module page_frame_allocator
    import pfa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port.
    input  wire logic                 i_cfg_we,
    input  wire logic [IDX_W-1:0]     i_cfg_idx,
    input  wire logic [REG_W-1:0]     i_cfg_wdata,
    // Request channel.
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_in_opcode,
    input  wire logic [IN_ADDR_W-1:0] i_in_free_address,
    // Result channel.
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [1:0]                o_out_status,
    output logic [ADDR_W-1:0]         o_out_page_address
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FREE   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    // Configuration registers.
    t_pfa_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mem_pages  <= REG_W'(NUM_PAGES);
            r_cfg.mmio_first <= REG_W'(NUM_PAGES);
            r_cfg.mmio_limit <= REG_W'(NUM_PAGES);
            r_cfg.kern_first <= '0;
            r_cfg.kern_end   <= '0;
            r_cfg.stack_page <= REG_W'(NUM_PAGES);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MEM_PAGES:  r_cfg.mem_pages  <= i_cfg_wdata;
                REG_MMIO_FIRST: r_cfg.mmio_first <= i_cfg_wdata;
                REG_MMIO_LIMIT: r_cfg.mmio_limit <= i_cfg_wdata;
                REG_KERN_FIRST: r_cfg.kern_first <= i_cfg_wdata;
                REG_KERN_END:   r_cfg.kern_end   <= i_cfg_wdata;
                REG_STACK_PAGE: r_cfg.stack_page <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Count RAM: one write port and one registered read port.
    logic [CNT_W-1:0]  r_mem [NUM_PAGES];
    logic [CNT_W-1:0]  r_rd_data;
    logic [PAGE_W-1:0] rd_addr;
    logic              mem_we;
    logic [PAGE_W-1:0] mem_waddr;
    logic [CNT_W-1:0]  mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Control and datapath registers.
    logic [PAGE_W-1:0] r_clr,      n_clr;
    logic [PAGE_W-1:0] r_scan_nxt, n_scan_nxt;
    logic [PAGE_W-1:0] r_rd_page,  n_rd_page;     // page whose count is in r_rd_data
    logic              r_free_ok,  n_free_ok;     // free address is aligned and in range
    t_pfa_status       r_res_sts,  n_res_sts;
    logic [PAGE_W-1:0] r_res_page, n_res_page;
    logic [CNT_W-1:0]  r_res_cnt,  n_res_cnt;
    logic              r_res_wr,   n_res_wr;
    logic              r_out_valid;
    t_pfa_status       r_out_sts;
    logic [ADDR_W-1:0] r_out_addr;

    logic in_accept;
    logic out_free;
    logic page_ok;
    logic scan_hit;
    logic load_out;
    logic free_addr_ok;

    pfa_page_check u_check (
        .i_page (r_rd_page),
        .i_cfg  (r_cfg),
        .o_ok   (page_ok)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign scan_hit   = page_ok && (r_rd_data == '0);
    assign load_out   = (r_state == S_RESULT) && out_free;

    // A free address must be non-null, page aligned and name a page below NUM_PAGES.
    assign free_addr_ok = (i_in_free_address != '0)
        && (i_in_free_address[PAGE_SHIFT-1:0] == '0)
        && (i_in_free_address[IN_ADDR_W-1:PAGE_SHIFT+PAGE_W] == '0);

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_scan_nxt = r_scan_nxt;
        n_rd_page  = r_rd_page;
        n_free_ok  = r_free_ok;
        n_res_sts  = r_res_sts;
        n_res_page = r_res_page;
        n_res_cnt  = r_res_cnt;
        n_res_wr   = r_res_wr;
        rd_addr    = r_scan_nxt;
        mem_we     = 1'b0;
        mem_waddr  = r_res_page;
        mem_wdata  = r_res_cnt;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                mem_wdata = '0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == PAGE_W'(NUM_PAGES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_accept) begin
                    if (i_in_opcode == OP_ALLOC) begin
                        rd_addr    = '0;
                        n_rd_page  = '0;
                        n_scan_nxt = PAGE_W'(1);
                        n_state    = S_SCAN;
                    end else begin
                        rd_addr   = i_in_free_address[PAGE_SHIFT +: PAGE_W];
                        n_rd_page = i_in_free_address[PAGE_SHIFT +: PAGE_W];
                        n_free_ok = free_addr_ok;
                        n_state   = S_FREE;
                    end
                end
            end
            S_SCAN: begin
                // One page is examined per cycle while the next one is read.
                n_rd_page  = r_scan_nxt;
                n_scan_nxt = r_scan_nxt + 1'b1;
                n_res_page = r_rd_page;
                if (scan_hit) begin
                    n_res_sts = STS_ALLOC;
                    n_res_cnt = (r_rd_data == COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;
                    n_res_wr  = 1'b1;
                    n_state   = S_RESULT;
                end else if (r_rd_page == PAGE_W'(NUM_PAGES - 1)) begin
                    n_res_sts = STS_OOM;
                    n_res_wr  = 1'b0;
                    n_state   = S_RESULT;
                end
            end
            S_FREE: begin
                n_res_page = r_rd_page;
                n_res_cnt  = r_rd_data - 1'b1;
                if (r_free_ok && page_ok && (r_rd_data != '0)) begin
                    n_res_sts = STS_FREED;
                    n_res_wr  = 1'b1;
                end else begin
                    n_res_sts = STS_IGNORED;
                    n_res_wr  = 1'b0;
                end
                n_state = S_RESULT;
            end
            S_RESULT: begin
                // The count is written back in the same cycle the result is posted.
                if (out_free) begin
                    mem_we  = r_res_wr;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_nxt <= n_scan_nxt;
        r_rd_page  <= n_rd_page;
        r_free_ok  <= n_free_ok;
        r_res_sts  <= n_res_sts;
        r_res_page <= n_res_page;
        r_res_cnt  <= n_res_cnt;
        r_res_wr   <= n_res_wr;
        if (load_out) begin
            r_out_sts  <= r_res_sts;
            r_out_addr <= (r_res_sts == STS_ALLOC)
                          ? ADDR_W'({r_res_page, {PAGE_SHIFT{1'b0}}}) : '0;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_out_status       = r_out_sts;
    assign o_out_page_address = r_out_addr;

    // The count RAM is only written by the clearing pass or while a result is posted.
    a_write_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_CLEAR || r_state == S_RESULT))
        else $error("count RAM written outside clear or result phase");

    // A granted page is never page 0.
    a_alloc_nonnull: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_status == STS_ALLOC) |-> (o_out_page_address != '0))
        else $error("allocation returned the null page");

    // Every other status carries a zero address.
    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_status != STS_ALLOC) |-> (o_out_page_address == '0))
        else $error("non-allocation result carries an address");

    // A posted result leaves the pipeline idle for the next request.
    a_post_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |=> (r_state == S_IDLE))
        else $error("controller did not return to idle after posting a result");

endmodule

`default_nettype wire

// ===== sv/pfa_page_check.sv =====
// Decides whether a page index may be handed out under the current memory map.
`default_nettype none

module pfa_page_check
    import pfa_pkg::*;
(
    input  wire logic [PAGE_W-1:0] i_page,
    input  wire t_pfa_cfg          i_cfg,
    output logic                   o_ok
);

    logic [REG_W-1:0] page_x;
    logic             in_mmio;
    logic             in_kern;

    assign page_x  = REG_W'(i_page);
    assign in_mmio = (page_x >= i_cfg.mmio_first) && (page_x < i_cfg.mmio_limit);
    assign in_kern = (page_x >= i_cfg.kern_first) && (page_x < i_cfg.kern_end);

    // Page 0 is never handed out so that a null address always means failure.
    assign o_ok = (page_x != '0) && (page_x < i_cfg.mem_pages) && !in_mmio
                  && !in_kern && (page_x != i_cfg.stack_page);

endmodule

`default_nettype wire

// ===== tb/sv/pfa_checker.sv =====
// Checker that predicts and compares every result beat of the page-frame allocator.
module pfa_checker
    import pfa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [IDX_W-1:0]     i_cfg_idx,
    input  wire logic [REG_W-1:0]     i_cfg_wdata,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic                 i_in_opcode,
    input  wire logic [IN_ADDR_W-1:0] i_in_free_address,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [1:0]           i_out_status,
    input  wire logic [ADDR_W-1:0]    i_out_page_address,
    input  wire logic                 i_end_check,
    output int                        o_pending,
    output int                        o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [IN_ADDR_W-1:0] OFFSET_MASK = (IN_ADDR_W'(1) << PAGE_SHIFT) - 1;

    typedef struct packed {
        t_pfa_status       status;
        logic [ADDR_W-1:0] page_address;
    } t_page_reply;

    t_pfa_cfg         cfg;
    logic [CNT_W-1:0] page_refs [NUM_PAGES];
    t_page_reply      awaited_replies [$];
    int               err_count = 0;

    task automatic report_mismatch(input string what);
        $display("[%0t] pfa_checker: %s", $time, what);
        err_count++;
    endtask

    function automatic bit page_usable(input int unsigned p);
        if (p == 0 || p >= NUM_PAGES || p >= cfg.mem_pages) return 1'b0;
        if (p >= cfg.mmio_first && p < cfg.mmio_limit) return 1'b0;
        if (p >= cfg.kern_first && p < cfg.kern_end) return 1'b0;
        if (p == cfg.stack_page) return 1'b0;
        return 1'b1;
    endfunction

    // Applies one request to the shadow reference counts and returns its reply.
    function automatic t_page_reply serve_request(input logic op,
                                                  input logic [IN_ADDR_W-1:0] addr);
        t_page_reply r;
        int unsigned p;
        r.status       = STS_IGNORED;
        r.page_address = '0;
        if (op == OP_ALLOC) begin
            r.status = STS_OOM;
            for (p = 0; p < NUM_PAGES; p++) begin
                if (page_usable(p) && page_refs[p] == '0) begin
                    if (page_refs[p] != COUNT_MAX) page_refs[p]++;
                    r.status       = STS_ALLOC;
                    r.page_address = ADDR_W'(p << PAGE_SHIFT);
                    return r;
                end
            end
            return r;
        end
        if (addr == '0 || (addr & OFFSET_MASK) != '0) return r;
        p = addr >> PAGE_SHIFT;
        if (!page_usable(p) || page_refs[p] == '0) return r;
        page_refs[p]--;
        r.status = STS_FREED;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_page_reply want;
        if (!i_rst_n) begin
            cfg.mem_pages  = REG_W'(NUM_PAGES);
            cfg.mmio_first = REG_W'(NUM_PAGES);
            cfg.mmio_limit = REG_W'(NUM_PAGES);
            cfg.kern_first = '0;
            cfg.kern_end   = '0;
            cfg.stack_page = REG_W'(NUM_PAGES);
            foreach (page_refs[i]) page_refs[i] = '0;
            awaited_replies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_MEM_PAGES:  cfg.mem_pages  = i_cfg_wdata;
                    REG_MMIO_FIRST: cfg.mmio_first = i_cfg_wdata;
                    REG_MMIO_LIMIT: cfg.mmio_limit = i_cfg_wdata;
                    REG_KERN_FIRST: cfg.kern_first = i_cfg_wdata;
                    REG_KERN_END:   cfg.kern_end   = i_cfg_wdata;
                    REG_STACK_PAGE: cfg.stack_page = i_cfg_wdata;
                    default: ;
                endcase
            end
            // Results are taken before new requests so that a stray result beat
            // never consumes the reply of a request accepted on the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (awaited_replies.size() == 0) begin
                    report_mismatch($sformatf("result beat status %0d addr %06h, none expected",
                                              i_out_status, i_out_page_address));
                end else begin
                    want = awaited_replies.pop_front();
                    if (i_out_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                                  i_out_status, want.status,
                                                  want.status.name()));
                    if (i_out_page_address !== want.page_address)
                        report_mismatch($sformatf("page address %06h, expected %06h",
                                                  i_out_page_address, want.page_address));
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_replies.push_back(serve_request(i_in_opcode, i_in_free_address));
            if (i_end_check && awaited_replies.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", awaited_replies.size()));
        end
        o_pending <= awaited_replies.size();
        o_errors  <= err_count;
    end

endmodule

// ===== tb/sv/tb_page_frame_allocator.sv =====
// Testbench top of the page-frame allocator: stimulus, flow control and verdict.
module tb_page_frame_allocator
    import pfa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // The run cannot take more than roughly 460 full scans plus stalls; the
    // limit below is several times that worst case, clearing pass included.
    localparam int RUN_LIMIT     = 3_000_000;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 55;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam logic OP_FREE = ~OP_ALLOC;
    // Indexes past the last register; writes to them must change nothing.
    localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(REG_STACK_PAGE) + 1'b1;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(REG_STACK_PAGE) + 2'd2;
    localparam logic [IN_ADDR_W-1:0] OFFSET_MASK = (IN_ADDR_W'(1) << PAGE_SHIFT) - 1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [IDX_W-1:0]     i_cfg_idx;
    logic [REG_W-1:0]     i_cfg_wdata;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_in_opcode;
    logic [IN_ADDR_W-1:0] i_in_free_address;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_out_status;
    logic [ADDR_W-1:0]    o_out_page_address;

    logic end_check;
    int   pending_cnt;
    int   fail_cnt;
    int   cycle_cnt = 0;
    int   burst_left;
    int   gap_max;

    page_frame_allocator u_top (.*);

    pfa_checker u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_in_opcode        (i_in_opcode),
        .i_in_free_address  (i_in_free_address),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_out_status       (o_out_status),
        .i_out_page_address (o_out_page_address),
        .i_end_check        (end_check),
        .o_pending          (pending_cnt),
        .o_errors           (fail_cnt)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog: a lost result or a stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == RUN_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side. The stall pattern changes from segment to segment between
    // never, light, medium and heavy stalling. Twice in the run the receiver
    // holds off for a long stretch; the allocator then has one request in
    // flight and one result parked, so it must push back on request beats.
    initial begin : result_sink
        int seg_left;
        int stall_pct;
        int rx_beats;
        int hold_left;
        bit first_hold_done;
        bit second_hold_done;
        seg_left         = 0;
        stall_pct        = 0;
        rx_beats         = 0;
        hold_left        = 0;
        first_hold_done  = 1'b0;
        second_hold_done = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) rx_beats++;
            if (hold_left == 0 && !first_hold_done && rx_beats >= 40) begin
                first_hold_done = 1'b1;
                hold_left       = HOLD_CYCLES;
            end else if (hold_left == 0 && !second_hold_done && rx_beats >= 250) begin
                second_hold_done = 1'b1;
                hold_left        = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(16, 128);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                end
                seg_left--;
                i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic logic [IN_ADDR_W-1:0] page_addr(input int unsigned pg);
        return IN_ADDR_W'(pg) << PAGE_SHIFT;
    endfunction

    // Offers one request beat and returns on the edge that accepts it. Beats
    // come in bursts; between bursts valid drops for a random gap. The valid
    // line is only lowered when a real gap follows, so it never gets two
    // assignments in one time step. The last beat of a phase always drops it.
    task automatic send_req(input logic op, input logic [IN_ADDR_W-1:0] addr,
                            input bit last);
        int gap;
        i_in_valid        <= 1'b1;
        i_in_opcode       <= op;
        i_in_free_address <= addr;
        do @(posedge i_clk); while (o_in_stall);
        burst_left--;
        if (last) begin
            i_in_valid <= 1'b0;
            burst_left = 0;
        end else if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(0, gap_max);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Waits until every expected result has been taken. The checker's count
    // is registered, hence the first wait. Every request yields a result, so
    // the block is idle once the count is zero; a short settle follows anyway.
    task automatic wait_idle();
        @(posedge i_clk);
        while (pending_cnt != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Writes all six registers on consecutive edges with the enable held high.
    // With spare set, the two unused indexes are written last with random data
    // to show that they leave the real registers alone.
    task automatic program_cfg(input t_pfa_cfg c, input bit spare);
        t_pfa_reg         regs [6];
        logic [REG_W-1:0] vals [6];
        regs = '{REG_MEM_PAGES, REG_MMIO_FIRST, REG_MMIO_LIMIT,
                 REG_KERN_FIRST, REG_KERN_END, REG_STACK_PAGE};
        vals = '{c.mem_pages, c.mmio_first, c.mmio_limit,
                 c.kern_first, c.kern_end, c.stack_page};
        for (int k = 0; k < 6; k++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_idx   <= regs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
        end
        if (spare) begin
            i_cfg_idx   <= REG_SPARE_LO;
            i_cfg_wdata <= REG_W'($urandom);
            @(posedge i_clk);
            i_cfg_idx   <= REG_SPARE_HI;
            i_cfg_wdata <= REG_W'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        t_pfa_cfg             c;
        int                   span;
        int                   alloc_pct;
        int                   pg;
        logic                 op;
        logic [IN_ADDR_W-1:0] addr;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= REG_MEM_PAGES;
        i_cfg_wdata       <= '0;
        i_in_valid        <= 1'b0;
        i_in_opcode       <= OP_ALLOC;
        i_in_free_address <= '0;
        end_check         <= 1'b0;
        burst_left = 0;
        gap_max    = 3;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: no window, no kernel image, all of memory present.
        // The first beat waits out the clearing pass behind the input stall.
        send_req(OP_ALLOC, $urandom, 1'b0);
        send_req(OP_ALLOC, $urandom, 1'b0);
        send_req(OP_FREE, page_addr(1), 1'b0);
        send_req(OP_FREE, page_addr(1), 1'b0);          // count already zero
        send_req(OP_FREE, '0, 1'b0);                    // null address
        send_req(OP_FREE, page_addr(1) | 1'b1, 1'b0);   // one byte past alignment
        send_req(OP_FREE, '1, 1'b0);                    // every bit set, unaligned
        send_req(OP_FREE, ~OFFSET_MASK, 1'b0);          // page far past the store
        send_req(OP_FREE, page_addr(NUM_PAGES), 1'b0);  // first page past the store
        send_req(OP_FREE, page_addr(NUM_PAGES - 1), 1'b0);
        send_req(OP_ALLOC, $urandom, 1'b1);             // takes the freed page back

        // Only page 0 present: nothing to allocate, and a held page cannot
        // be freed because it is no longer allocatable.
        wait_idle();
        c = '{mem_pages: 11'd1, mmio_first: 11'd1024, mmio_limit: 11'd1024,
              kern_first: 11'd0, kern_end: 11'd0, stack_page: 11'd1024};
        program_cfg(c, 1'b1);
        send_req(OP_ALLOC, $urandom, 1'b0);
        send_req(OP_FREE, page_addr(1), 1'b1);

        // Memory size above the store, with kernel image, device window and
        // stack page all reserved near the bottom.
        wait_idle();
        c = '{mem_pages: 11'd2047, mmio_first: 11'd6, mmio_limit: 11'd8,
              kern_first: 11'd1, kern_end: 11'd4, stack_page: 11'd9};
        program_cfg(c, 1'b1);
        repeat (4) send_req(OP_ALLOC, $urandom, 1'b0);
        send_req(OP_FREE, page_addr(6), 1'b0);          // inside the device window
        send_req(OP_FREE, page_addr(9), 1'b0);          // the stack page
        send_req(OP_FREE, page_addr(2), 1'b1);          // held, but in the kernel image

        // Both windows empty because their ends are not above their starts.
        wait_idle();
        c = '{mem_pages: 11'd1024, mmio_first: 11'd20, mmio_limit: 11'd5,
              kern_first: 11'd1023, kern_end: 11'd0, stack_page: 11'd2047};
        program_cfg(c, 1'b0);
        send_req(OP_ALLOC, $urandom, 1'b0);
        send_req(OP_FREE, page_addr(2), 1'b0);
        send_req(OP_FREE, page_addr(7), 1'b0);
        send_req(OP_ALLOC, $urandom, 1'b1);

        // Windows that cover every page leave nothing to allocate.
        wait_idle();
        c = '{mem_pages: 11'd1024, mmio_first: 11'd0, mmio_limit: 11'd2047,
              kern_first: 11'd0, kern_end: 11'd2047, stack_page: 11'd0};
        program_cfg(c, 1'b0);
        send_req(OP_ALLOC, $urandom, 1'b1);

        // Random phases. Most use a small memory so that allocations run into
        // exhaustion and most frees name pages that are really held; a few
        // use a large or empty memory. Frees are mostly aligned addresses of
        // low pages, mixed with null, unaligned and far-out addresses.
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 9))
                0:       c.mem_pages = '0;
                1:       c.mem_pages = REG_W'(NUM_PAGES);
                2:       c.mem_pages = '1;
                3:       c.mem_pages = REG_W'($urandom_range(49, 2047));
                default: c.mem_pages = REG_W'($urandom_range(2, 48));
            endcase
            span = (c.mem_pages > 48) ? 48 : int'(c.mem_pages);
            c.mmio_first = REG_W'($urandom_range(0, span + 4));
            c.mmio_limit = REG_W'($urandom_range(0, span + 4));
            c.kern_first = REG_W'($urandom_range(0, span + 4));
            c.kern_end   = REG_W'($urandom_range(0, span + 4));
            c.stack_page = ($urandom_range(0, 3) == 0) ? '1
                                                       : REG_W'($urandom_range(0, span + 2));
            gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 6;
            alloc_pct = $urandom_range(30, 70);
            wait_idle();
            program_cfg(c, ph == 0);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pg = $urandom_range(0, span + 3);
                case ($urandom_range(0, 19))
                    0:       addr = '0;
                    1:       addr = $urandom;
                    2:       addr = $urandom & ~OFFSET_MASK;
                    3:       addr = page_addr(pg) | $urandom_range(1, int'(OFFSET_MASK));
                    default: addr = page_addr(pg);
                endcase
                op = ($urandom_range(0, 99) < alloc_pct) ? OP_ALLOC : OP_FREE;
                // Allocate ignores the address, so it carries random bits.
                if (op == OP_ALLOC) addr = $urandom;
                send_req(op, addr, n == PHASE_ITEMS - 1);
            end
        end

        // Drain, let any stray beat show up, then ask the checker for leftovers.
        wait_idle();
        end_check <= 1'b1;
        @(posedge i_clk);
        end_check <= 1'b0;
        repeat (2) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
